// ===== rtl/core/stun_pkg.sv =====
// shared types and constants for the stun binding response parser
`default_nettype none

package stun_pkg;

  // result status codes; the error register uses the same codes, ok meaning no error
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_NOT_SUCCESS = 3'd2,
    ST_COOKIE      = 3'd3,
    ST_TXID        = 3'd4,
    ST_BAD_LEN     = 3'd5,
    ST_NOT_IPV4    = 3'd6,
    ST_NONE        = 3'd7
  } status_t;

  localparam logic [31:0] STUN_COOKIE     = 32'h2112A442;
  localparam logic [15:0] MSG_TYPE        = 16'h0101;
  localparam logic [13:0] ATTR_MAPPED     = 14'h0001;
  localparam logic [13:0] ATTR_XOR_MAPPED = 14'h0020;
  localparam logic [7:0]  FAMILY_IPV4     = 8'h01;
  localparam logic [15:0] ADDR_ATTR_LEN   = 16'd8;
  localparam int          HDR_BYTES       = 20;
  localparam logic [47:0] XOR_KEY         = {STUN_COOKIE[31:16], STUN_COOKIE};

  // one byte on its way into the parser
  typedef struct packed {
    logic       take;
    logic       last;
    logic [7:0] data;
  } byte_ctl_t;

  // one parse result
  typedef struct packed {
    status_t     status;
    logic [31:0] public_ip;
    logic [15:0] public_port;
    logic        from_xor;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/stun_in_if.sv =====
// byte channel into the parser
`default_nettype none

interface stun_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_packet;

  modport source (output valid, output rx_byte, output end_of_packet, input ready);
  modport sink (input valid, input rx_byte, input end_of_packet, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stun_out_if.sv =====
// result channel out of the parser
`default_nettype none

interface stun_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] public_ip;
  logic [15:0] public_port;
  logic        from_xor;

  modport source (output valid, output status, output public_ip, output public_port,
                  output from_xor, input ready);
  modport sink (input valid, input status, input public_ip, input public_port,
                input from_xor, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stun_step.sv =====
// parse state and per-byte next-state logic
`default_nettype none

module stun_step #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  wire                clk,
  input  wire                rst,
  input  stun_pkg::byte_ctl_t ctl,
  input  wire  [31:0]        txid_high,
  input  wire  [63:0]        txid_low,
  output stun_pkg::result_t  result
);
  import stun_pkg::*;

  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_ATTR_HDR = 3'd1,
    PH_ADDR     = 3'd2,
    PH_SKIP     = 3'd3,
    PH_DONE     = 3'd4
  } phase_t;

  logic [POS_W-1:0] byte_position, byte_position_next;
  phase_t           parse_phase, parse_phase_next;
  logic [31:0]      word_gather, word_gather_next;
  logic [13:0]      attr_kind, attr_kind_next;
  logic [16:0]      attr_bytes_left, attr_bytes_left_next;
  logic [47:0]      addr_gather, addr_gather_next;
  logic [47:0]      xor_address, xor_address_next;
  logic             xor_found, xor_found_next;
  logic [47:0]      plain_address, plain_address_next;
  logic             plain_found, plain_found_next;
  status_t          error_code, error_code_next;

  logic [159:0] hdr_word;
  logic [4:0]   hdr_idx;
  logic [7:0]   hdr_expect;
  status_t      hdr_error;
  logic [31:0]  wg_shift;
  logic [15:0]  attr_len;
  logic [13:0]  kind_new;
  logic [1:0]   pad;
  logic [3:0]   addr_idx;
  logic         keep;

  // expected header bytes, message length bytes are ignored
  assign hdr_word   = {MSG_TYPE, 16'h0000, STUN_COOKIE, txid_high, txid_low};
  assign hdr_idx    = 5'd19 - byte_position[4:0];
  assign hdr_expect = hdr_word[{hdr_idx, 3'b000} +: 8];

  always_comb begin
    if (byte_position < POS_W'(2)) begin
      hdr_error = ST_NOT_SUCCESS;
    end else if (byte_position < POS_W'(8)) begin
      hdr_error = ST_COOKIE;
    end else begin
      hdr_error = ST_TXID;
    end
  end

  assign wg_shift = {word_gather[23:0], ctl.data};
  assign attr_len = wg_shift[15:0];
  assign kind_new = wg_shift[29:16];
  assign pad      = 2'(3'd4 - {1'b0, attr_len[1:0]});
  assign addr_idx = 4'd8 - attr_bytes_left[3:0];
  assign keep     = byte_position < POS_W'(MAX_PACKET_BYTES);

  // next state for one byte
  always_comb begin
    byte_position_next   = byte_position;
    parse_phase_next     = parse_phase;
    word_gather_next     = word_gather;
    attr_kind_next       = attr_kind;
    attr_bytes_left_next = attr_bytes_left;
    addr_gather_next     = addr_gather;
    xor_address_next     = xor_address;
    xor_found_next       = xor_found;
    plain_address_next   = plain_address;
    plain_found_next     = plain_found;
    error_code_next      = error_code;
    if (keep) begin
      byte_position_next = byte_position + POS_W'(1);
      unique case (parse_phase)
        PH_HEADER: begin
          if (byte_position != POS_W'(2) && byte_position != POS_W'(3) &&
              error_code == ST_OK && ctl.data != hdr_expect) begin
            error_code_next = hdr_error;
          end
          if (byte_position == POS_W'(HDR_BYTES - 1)) begin
            parse_phase_next = (error_code_next == ST_OK) ? PH_ATTR_HDR : PH_DONE;
          end
        end
        PH_ATTR_HDR: begin
          word_gather_next = wg_shift;
          if (byte_position[1:0] == 2'd3) begin
            attr_kind_next   = kind_new;
            word_gather_next = '0;
            if (kind_new == ATTR_MAPPED || kind_new == ATTR_XOR_MAPPED) begin
              if (attr_len != ADDR_ATTR_LEN) begin
                error_code_next  = ST_BAD_LEN;
                parse_phase_next = PH_DONE;
              end else begin
                attr_bytes_left_next = 17'd8;
                addr_gather_next     = '0;
                parse_phase_next     = PH_ADDR;
              end
            end else begin
              attr_bytes_left_next = {1'b0, attr_len} + 17'(pad);
              parse_phase_next     = ({1'b0, attr_len} + 17'(pad) == 17'd0) ?
                                     PH_ATTR_HDR : PH_SKIP;
            end
          end
        end
        PH_ADDR: begin
          if (addr_idx == 4'd1) begin
            word_gather_next = {24'h0, ctl.data};
          end else if (addr_idx >= 4'd2) begin
            addr_gather_next = {addr_gather[39:0], ctl.data};
          end
          attr_bytes_left_next = attr_bytes_left - 17'd1;
          if (attr_bytes_left == 17'd1) begin
            if (word_gather_next != {24'h0, FAMILY_IPV4}) begin
              error_code_next  = ST_NOT_IPV4;
              parse_phase_next = PH_DONE;
            end else begin
              if (attr_kind == ATTR_XOR_MAPPED) begin
                xor_address_next = addr_gather_next ^ XOR_KEY;
                xor_found_next   = 1'b1;
              end else begin
                plain_address_next = addr_gather_next;
                plain_found_next   = 1'b1;
              end
              parse_phase_next = PH_ATTR_HDR;
            end
            word_gather_next = '0;
          end
        end
        PH_SKIP: begin
          attr_bytes_left_next = attr_bytes_left - 17'd1;
          if (attr_bytes_left == 17'd1) begin
            parse_phase_next = PH_ATTR_HDR;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // verdict on the final byte, from the state after that byte
  always_comb begin
    result.public_ip   = '0;
    result.public_port = '0;
    result.from_xor    = 1'b0;
    priority if (byte_position_next < POS_W'(HDR_BYTES)) begin
      result.status = ST_SHORT;
    end else if (error_code_next == ST_NOT_SUCCESS || error_code_next == ST_COOKIE ||
                 error_code_next == ST_TXID) begin
      result.status = error_code_next;
    end else if (xor_found_next) begin
      result.status      = ST_OK;
      result.public_ip   = xor_address_next[31:0];
      result.public_port = xor_address_next[47:32];
      result.from_xor    = 1'b1;
    end else if (plain_found_next) begin
      result.status      = ST_OK;
      result.public_ip   = plain_address_next[31:0];
      result.public_port = plain_address_next[47:32];
    end else if (parse_phase_next == PH_ADDR) begin
      result.status = ST_BAD_LEN;
    end else if (error_code_next != ST_OK) begin
      result.status = error_code_next;
    end else begin
      result.status = ST_NONE;
    end
  end

  // parse state, cleared after each final byte
  always_ff @(posedge clk) begin
    if (rst || (ctl.take && ctl.last)) begin
      byte_position   <= '0;
      parse_phase     <= PH_HEADER;
      word_gather     <= '0;
      attr_kind       <= '0;
      attr_bytes_left <= '0;
      addr_gather     <= '0;
      xor_address     <= '0;
      xor_found       <= 1'b0;
      plain_address   <= '0;
      plain_found     <= 1'b0;
      error_code      <= ST_OK;
    end else if (ctl.take) begin
      byte_position   <= byte_position_next;
      parse_phase     <= parse_phase_next;
      word_gather     <= word_gather_next;
      attr_kind       <= attr_kind_next;
      attr_bytes_left <= attr_bytes_left_next;
      addr_gather     <= addr_gather_next;
      xor_address     <= xor_address_next;
      xor_found       <= xor_found_next;
      plain_address   <= plain_address_next;
      plain_found     <= plain_found_next;
      error_code      <= error_code_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stun_binding_response_parser_unit.sv =====
// top level of the stun binding response parser
//
// pkt carries the response one byte per transfer, end_of_packet set on the
// last byte of the datagram. res carries one result per datagram: status,
// public address, port and whether the xor-mapped attribute supplied it.
// the expected transaction id is written through cfg_we / cfg_index /
// cfg_data: index 0 is the upper 32 bits, index 1 the lower 64 bits.
// a byte is taken into an input register, then parsed by the byte-wise
// next-state logic as it leaves that register, and a final byte loads the
// result register at that edge; a result thus passes through the input
// register and then the result register. throughput is one byte per cycle,
// set by the single-byte parse step, unless a final byte meets a stalled result.
// bytes past MAX_PACKET_BYTES within one datagram are dropped.
// reset clears the parse state, both channels and the transaction id.
// while res is stalled with a result waiting, ordinary bytes keep flowing;
// only a second final byte waits in the input register, and pkt.ready
// drops until the waiting result transfers.
`default_nettype none

module stun_binding_response_parser_unit #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  wire          clk,
  input  wire          rst,
  stun_in_if.sink      pkt,
  stun_out_if.source   res,
  input  wire          cfg_we,
  input  wire  [0:0]   cfg_index,
  input  wire  [63:0]  cfg_data
);
  import stun_pkg::*;

  localparam logic [0:0] REG_TXID_HIGH = 1'd0;
  localparam logic [0:0] REG_TXID_LOW  = 1'd1;

  logic [31:0] txid_high;
  logic [63:0] txid_low;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        advance;
  byte_ctl_t   ctl;
  result_t     step_result;
  logic        res_valid;
  result_t     res_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      txid_high <= '0;
      txid_low  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TXID_HIGH: txid_high <= cfg_data[31:0];
        REG_TXID_LOW:  txid_low  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input stage moves on unless a final byte meets a stalled result
  assign advance   = in_valid && (!in_last || !res_valid || res.ready);
  assign pkt.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pkt.ready) begin
      in_valid <= pkt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.valid && pkt.ready) begin
      in_byte <= pkt.rx_byte;
      in_last <= pkt.end_of_packet;
    end
  end

  assign ctl = '{take: advance, last: in_last, data: in_byte};

  stun_step #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .txid_high (txid_high),
    .txid_low  (txid_low),
    .result    (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && in_last) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      res_data <= step_result;
    end
  end

  assign res.valid       = res_valid;
  assign res.status      = res_data.status;
  assign res.public_ip   = res_data.public_ip;
  assign res.public_port = res_data.public_port;
  assign res.from_xor    = res_data.from_xor;

`ifndef SYNTHESIS
  // a failed parse reports no address
  a_no_addr_on_error: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status != ST_OK |->
      res_data.public_ip == '0 && res_data.public_port == '0 && !res_data.from_xor)
    else $error("address reported with error status");

  // a new result only follows a final byte leaving the input stage
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(advance && in_last))
    else $error("result without final byte");

  // a final byte must wait while a result is stalled
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_last && res_valid && !res.ready |-> !pkt.ready && !advance)
    else $error("final byte overran stalled result");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_stun_binding_response_parser_unit.sv =====
// testbench for the stun binding response parser: directed and random packets against a predictor
`timescale 1ns / 100ps

module tb_stun_binding_response_parser_unit;
  import stun_pkg::*;

  localparam int MAX_PKT        = 2048;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BYTES   = 740;
  localparam int RANDOM_PACKETS = 16;
  localparam int DRAIN_CYCLES   = 6;

  localparam logic [0:0]  REG_TXID_HIGH     = 1'b0;
  localparam logic [0:0]  REG_TXID_LOW      = 1'b1;
  localparam logic [15:0] ATTR_SOFTWARE     = 16'h8022;
  localparam logic [15:0] ATTR_FINGERPRINT  = 16'h8028;
  localparam logic [15:0] ATTR_MAPPED_UPPER = {2'b11, ATTR_MAPPED};

  // where the predictor stands inside a datagram
  typedef enum logic [2:0] {
    WALK_HEADER, WALK_ATTR_HDR, WALK_ADDR, WALK_SKIP, WALK_DONE
  } walk_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [63:0] cfg_data;

  stun_in_if  pkt_ch ();
  stun_out_if res_ch ();

  stun_binding_response_parser_unit #(.MAX_PACKET_BYTES(MAX_PKT)) DUT (
    .clk(clk),
    .rst(rst),
    .pkt(pkt_ch),
    .res(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state: expected transaction id and the walk through one datagram
  logic [31:0] txid_hi_q;
  logic [63:0] txid_lo_q;
  int          walk_pos;
  walk_t       walk;
  logic [31:0] word_acc;
  logic [13:0] attr_type;
  logic [16:0] attr_remain;
  logic [47:0] addr_acc;
  logic [47:0] xor_value;
  logic        xor_seen;
  logic [47:0] map_addr;
  logic        map_seen;
  status_t     walk_err;

  result_t     pending_results [$];
  logic [7:0]  pkt_bytes [$];
  int          burst_left = 0;
  int          err_count = 0;
  int          idle_cycles = 0;

  function automatic void clear_walk();
    walk_pos    = 0;
    walk        = WALK_HEADER;
    word_acc    = '0;
    attr_type   = '0;
    attr_remain = '0;
    addr_acc    = '0;
    xor_value   = '0;
    xor_seen    = 1'b0;
    map_addr    = '0;
    map_seen    = 1'b0;
    walk_err    = ST_OK;
  endfunction

  function automatic logic [7:0] hdr_expected(int p);
    if (p < 2) return MSG_TYPE[8*(1-p) +: 8];
    if (p < 8) return STUN_COOKIE[8*(7-p) +: 8];
    if (p < 12) return txid_hi_q[8*(11-p) +: 8];
    return txid_lo_q[8*(19-p) +: 8];
  endfunction

  // one byte through the parse walk
  function automatic void walk_byte(logic [7:0] b);
    logic [15:0] len;
    logic [1:0]  pad;
    int          idx;
    case (walk)
      WALK_HEADER: begin
        // the message length bytes are not checked
        if ((walk_pos < 2 || walk_pos >= 4) && walk_err == ST_OK) begin
          if (b != hdr_expected(walk_pos)) begin
            if (walk_pos < 2) walk_err = ST_NOT_SUCCESS;
            else if (walk_pos < 8) walk_err = ST_COOKIE;
            else walk_err = ST_TXID;
          end
        end
        if (walk_pos == HDR_BYTES - 1) begin
          if (walk_err == ST_OK) walk = WALK_ATTR_HDR;
          else walk = WALK_DONE;
        end
      end
      WALK_ATTR_HDR: begin
        word_acc = {word_acc[23:0], b};
        if (walk_pos % 4 == 3) begin
          len = word_acc[15:0];
          attr_type = word_acc[29:16];
          if (attr_type == ATTR_MAPPED || attr_type == ATTR_XOR_MAPPED) begin
            if (len != ADDR_ATTR_LEN) begin
              walk_err = ST_BAD_LEN;
              walk = WALK_DONE;
            end else begin
              attr_remain = 17'd8;
              addr_acc = '0;
              walk = WALK_ADDR;
            end
          end else begin
            pad = 2'd0 - len[1:0];
            attr_remain = {1'b0, len} + {15'd0, pad};
            if (attr_remain == '0) walk = WALK_ATTR_HDR;
            else walk = WALK_SKIP;
          end
          word_acc = '0;
        end
      end
      WALK_ADDR: begin
        // reserved byte, family byte, then port and address
        idx = 8 - int'(attr_remain);
        if (idx == 1) word_acc = {24'd0, b};
        else if (idx >= 2) addr_acc = {addr_acc[39:0], b};
        attr_remain = attr_remain - 17'd1;
        if (attr_remain == '0) begin
          if (word_acc != {24'd0, FAMILY_IPV4}) begin
            walk_err = ST_NOT_IPV4;
            walk = WALK_DONE;
          end else begin
            if (attr_type == ATTR_XOR_MAPPED) begin
              xor_value = addr_acc ^ XOR_KEY;
              xor_seen = 1'b1;
            end else begin
              map_addr = addr_acc;
              map_seen = 1'b1;
            end
            walk = WALK_ATTR_HDR;
          end
          word_acc = '0;
        end
      end
      WALK_SKIP: begin
        attr_remain = attr_remain - 17'd1;
        if (attr_remain == '0) walk = WALK_ATTR_HDR;
      end
      default: ;
    endcase
  endfunction

  // accepted byte: advance the walk and, on the final byte, queue the verdict
  function automatic void predict_byte(logic [7:0] b, logic last);
    result_t r;
    if (walk_pos < MAX_PKT) begin
      walk_byte(b);
      walk_pos++;
    end
    if (last) begin
      r.public_ip = '0;
      r.public_port = '0;
      r.from_xor = 1'b0;
      if (walk_pos < HDR_BYTES) begin
        r.status = ST_SHORT;
      end else if (walk_err == ST_NOT_SUCCESS || walk_err == ST_COOKIE
                   || walk_err == ST_TXID) begin
        r.status = walk_err;
      end else if (xor_seen) begin
        r.status = ST_OK;
        {r.public_port, r.public_ip} = xor_value;
        r.from_xor = 1'b1;
      end else if (map_seen) begin
        r.status = ST_OK;
        {r.public_port, r.public_ip} = map_addr;
      end else if (walk == WALK_ADDR) begin
        r.status = ST_BAD_LEN;
      end else if (walk_err != ST_OK) begin
        r.status = walk_err;
      end else begin
        r.status = ST_NONE;
      end
      pending_results = {pending_results, r};
      clear_walk();
    end
  endfunction

  // packet building
  function automatic void put_be(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) pkt_bytes = {pkt_bytes, v[8*i +: 8]};
  endfunction

  function automatic void put_header();
    put_be(MSG_TYPE, 2);
    put_be($urandom, 2);
    put_be(STUN_COOKIE, 4);
    put_be(txid_hi_q, 4);
    put_be(txid_lo_q, 8);
  endfunction

  function automatic void put_addr_attr(logic [15:0] type_word, logic [15:0] len,
                                        logic [7:0] fam, logic [47:0] wire_val);
    put_be(type_word, 2);
    put_be(len, 2);
    if (len == ADDR_ATTR_LEN) begin
      put_be($urandom, 1);
      put_be(fam, 1);
      put_be(wire_val, 6);
    end
  endfunction

  function automatic void put_mapped(logic [47:0] wire_val);
    put_addr_attr({2'b00, ATTR_MAPPED}, ADDR_ATTR_LEN, FAMILY_IPV4, wire_val);
  endfunction

  function automatic void put_xor(logic [47:0] wire_val);
    put_addr_attr({2'b00, ATTR_XOR_MAPPED}, ADDR_ATTR_LEN, FAMILY_IPV4, wire_val);
  endfunction

  // unknown attribute with its padded body, minus cut bytes at the end
  function automatic void put_skip_attr(logic [15:0] type_word, logic [15:0] len, int cut);
    int body;
    body = int'(len) + ((4 - int'(len) % 4) % 4) - cut;
    put_be(type_word, 2);
    put_be(len, 2);
    repeat (body) put_be($urandom, 1);
  endfunction

  function automatic void corrupt(int pos);
    pkt_bytes[pos] = pkt_bytes[pos] ^ 8'($urandom_range(1, 255));
  endfunction

  function automatic void truncate_to(int n);
    if (pkt_bytes.size() > n) pkt_bytes = pkt_bytes[0:n-1];
  endfunction

  function automatic logic [47:0] rand_addr();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return XOR_KEY;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  function automatic void put_random_attr();
    logic [1:0]  top;
    logic [13:0] kind;
    logic [15:0] len;
    logic [7:0]  fam;
    top = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 0) kind = ATTR_MAPPED;
    else kind = ATTR_XOR_MAPPED;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: put_addr_attr({top, kind}, ADDR_ATTR_LEN, FAMILY_IPV4, rand_addr());
      6: begin
        len = 16'($urandom);
        if (len == ADDR_ATTR_LEN) len = len + 16'd1;
        put_addr_attr({top, kind}, len, FAMILY_IPV4, rand_addr());
      end
      7: begin
        fam = 8'($urandom);
        if (fam == FAMILY_IPV4) fam = 8'h00;
        put_addr_attr({top, kind}, ADDR_ATTR_LEN, fam, rand_addr());
      end
      default: begin
        kind = 14'($urandom);
        if (kind == ATTR_MAPPED || kind == ATTR_XOR_MAPPED) kind = kind + 14'd2;
        if ($urandom_range(0, 15) == 0) len = 16'($urandom_range(13, 120));
        else len = 16'($urandom_range(0, 12));
        put_skip_attr({top, kind}, len, 0);
      end
    endcase
  endfunction

  function automatic void build_random_packet();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // short datagram: a header prefix or plain noise
      if ($urandom_range(0, 1) == 0) put_header();
      else repeat (19) put_be($urandom, 1);
      truncate_to($urandom_range(1, HDR_BYTES - 1));
    end else if (pick < 18) begin
      repeat ($urandom_range(HDR_BYTES, 48)) put_be($urandom, 1);
    end else begin
      put_header();
      if ($urandom_range(0, 9) == 0) corrupt($urandom_range(0, HDR_BYTES - 1));
      repeat ($urandom_range(0, 4)) put_random_attr();
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) put_be($urandom, 1);
      if ($urandom_range(0, 7) == 0) truncate_to($urandom_range(1, pkt_bytes.size()));
    end
  endfunction

  // one byte transfer, with bursts and random gaps on the sender side
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        pkt_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    pkt_ch.valid <= 1'b1;
    pkt_ch.rx_byte <= b;
    pkt_ch.end_of_packet <= last;
    @(posedge clk);
    while (!pkt_ch.ready) @(posedge clk);
    predict_byte(b, last);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++)
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    pkt_bytes.delete();
  endtask

  // stop sending and wait until every verdict is back
  task automatic drain_results();
    @(negedge clk);
    pkt_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TXID_HIGH) txid_hi_q = value[31:0];
    else txid_lo_q = value;
  endtask

  task automatic set_txid(logic [63:0] hi_word, logic [63:0] lo_word);
    write_reg(REG_TXID_HIGH, hi_word);
    write_reg(REG_TXID_LOW, lo_word);
  endtask

  // transaction id still at its reset value of zero
  task automatic test_reset_txid();
    put_header();
    put_xor(rand_addr());
    send_packet();
    put_header();
    put_mapped(rand_addr());
    send_packet();
  endtask

  task automatic test_header_checks();
    drain_results();
    set_txid('1, '1);
    // wrong message type, address after it ignored
    put_header();
    corrupt(0);
    put_xor(rand_addr());
    send_packet();
    // type and cookie both wrong: the first failing byte decides
    put_header();
    corrupt(1);
    corrupt(5);
    send_packet();
    put_header();
    corrupt(7);
    put_mapped(rand_addr());
    send_packet();
    drain_results();
    set_txid(64'hFFFF_FFFF_0000_0000, '0);
    put_header();
    corrupt(8);
    send_packet();
    put_header();
    corrupt(19);
    put_mapped(rand_addr());
    send_packet();
    // short datagrams, whatever else is wrong
    put_header();
    truncate_to(HDR_BYTES - 1);
    send_packet();
    put_be(8'hFF, 1);
    send_packet();
    // header alone, no address
    put_header();
    send_packet();
  endtask

  task automatic test_attribute_walk();
    drain_results();
    set_txid({$urandom, $urandom}, {$urandom, $urandom});
    // empty unknown attribute, then plain before xor: xor preferred
    put_header();
    put_skip_attr(ATTR_FINGERPRINT, 16'd0, 0);
    put_mapped(rand_addr());
    put_xor(rand_addr());
    send_packet();
    put_header();
    put_xor(rand_addr());
    put_mapped(rand_addr());
    send_packet();
    // repeated plain address: the later one wins
    put_header();
    put_mapped(rand_addr());
    put_mapped(rand_addr());
    send_packet();
    // top type bits masked, all-zero address still counts
    put_header();
    put_addr_attr(ATTR_MAPPED_UPPER, ADDR_ATTR_LEN, FAMILY_IPV4, '0);
    send_packet();
    put_header();
    put_xor(XOR_KEY);
    send_packet();
    // attribute errors
    put_header();
    put_addr_attr({2'b00, ATTR_MAPPED}, 16'd12, FAMILY_IPV4, rand_addr());
    put_xor(rand_addr());
    send_packet();
    put_header();
    put_addr_attr({2'b00, ATTR_XOR_MAPPED}, ADDR_ATTR_LEN, 8'h02, rand_addr());
    send_packet();
    // earlier address survives a later attribute error
    put_header();
    put_mapped(rand_addr());
    put_addr_attr({2'b00, ATTR_XOR_MAPPED}, ADDR_ATTR_LEN, 8'h02, rand_addr());
    send_packet();
    // address cut short by the end of the datagram
    put_header();
    put_mapped(rand_addr());
    truncate_to(HDR_BYTES + 9);
    send_packet();
    // short tail after an address, and a tail alone
    put_header();
    put_mapped(rand_addr());
    repeat (3) put_be($urandom, 1);
    send_packet();
    put_header();
    repeat (2) put_be($urandom, 1);
    send_packet();
    // skipped attribute cut short, odd length with padding
    put_header();
    put_skip_attr(ATTR_SOFTWARE, 16'd20, 14);
    send_packet();
    put_header();
    put_skip_attr(ATTR_SOFTWARE, 16'd5, 0);
    put_xor(rand_addr());
    send_packet();
  endtask

  task automatic test_random_traffic();
    int phase_bytes;
    int phase_pkts;
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        1: set_txid('0, '1);
        2: set_txid('1, '0);
        default: set_txid({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      phase_bytes = 0;
      phase_pkts = 0;
      while (phase_bytes < RANDOM_BYTES / 4 || phase_pkts < RANDOM_PACKETS / 4) begin
        build_random_packet();
        phase_bytes += pkt_bytes.size();
        send_packet();
        phase_pkts++;
        // now and then hold off until all verdicts are back
        if ($urandom_range(0, 19) == 0) drain_results();
      end
    end
    drain_results();
  endtask

  task automatic report(string what, result_t want, result_t got);
    err_count++;
    if (err_count <= 10)
      $display({"mismatch (%s): expected status=%0d ip=%h port=%h xor=%b,",
                " got status=%0d ip=%h port=%h xor=%b"},
               what, want.status, want.public_ip, want.public_port, want.from_xor,
               got.status, got.public_ip, got.public_port, got.from_xor);
  endtask

  // result receiver stalls on its own pattern of modes
  initial begin : result_stall
    int mode;
    int span;
    res_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom_range(0, 1));
          2: res_ch.ready <= ($urandom_range(0, 7) != 0);
          default: res_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  // result check against the oldest expectation, plus the watchdog
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    string   bad;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.status = status_t'(res_ch.status);
      got.public_ip = res_ch.public_ip;
      got.public_port = res_ch.public_port;
      got.from_xor = res_ch.from_xor;
      if (pending_results.size() == 0) begin
        report("no result expected", '0, got);
      end else begin
        want = pending_results.pop_front();
        bad = "";
        if (got.status !== want.status) bad = {bad, " status"};
        if (got.public_ip !== want.public_ip) bad = {bad, " public_ip"};
        if (got.public_port !== want.public_port) bad = {bad, " public_port"};
        if (got.from_xor !== want.from_xor) bad = {bad, " from_xor"};
        if (bad != "") report(bad, want, got);
      end
    end
    if (rst || (pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_stun_binding_response_parser_unit: errors");
      $finish;
    end
  end

  initial begin
    pkt_ch.valid = 1'b0;
    pkt_ch.rx_byte = '0;
    pkt_ch.end_of_packet = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_TXID_HIGH;
    cfg_data = '0;
    txid_hi_q = '0;
    txid_lo_q = '0;
    clear_walk();
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_reset_txid();
    test_header_checks();
    test_attribute_walk();
    test_random_traffic();
    if (pending_results.size() != 0) err_count++;
    if (err_count == 0)
      $display("tb_stun_binding_response_parser_unit: clean");
    else
      $display("tb_stun_binding_response_parser_unit: errors");
    $finish;
  end

endmodule

// ===== stun_binding_response_parser_unit.f =====
rtl/core/stun_pkg.sv
rtl/core/stun_in_if.sv
rtl/core/stun_out_if.sv
rtl/core/stun_step.sv
rtl/core/stun_binding_response_parser_unit.sv
sim/tb_stun_binding_response_parser_unit.sv
